>>> rtl/core/lbs_pkg.sv
// Package for the LSB-first bit stream store: sizes, action and status codes,
// controller state type and the command/status structs between controller and datapath.
// No dependencies.
package lbs_pkg;

    // Capacity of the byte memory
    localparam int CAP_BYTES = 1024;
    localparam int BYTE_W    = 8;
    localparam int CAP_BITS  = CAP_BYTES * BYTE_W;
    localparam int ADDR_W    = $clog2(CAP_BYTES);

    // Port field widths
    localparam int ACT_W   = 2;
    localparam int VAL_W   = 64;
    localparam int LEN_W   = 7;
    localparam int FILL_W  = 14;
    localparam int STAT_W  = 3;
    localparam int BYTES_W = 11;

    localparam int MAX_FIELD = 64;

    // A field plus up to seven leading bits spans nine bytes
    localparam int SPAN_W   = VAL_W + BYTE_W;
    localparam int RD_BYTES = SPAN_W / BYTE_W;
    localparam int CNT_W    = $clog2(RD_BYTES + 1);

    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_LEN = 3'd1;
    localparam logic [STAT_W-1:0] ST_OFFSET  = 3'd2;
    localparam logic [STAT_W-1:0] ST_SPAN    = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WRITE = 5'b00010,
        S_READ  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // take the input transaction, check it, set up the byte walk
        logic wr_step;   // write one byte, advance
        logic rd_step;   // issue one byte read, advance
        logic publish;   // move the finished result into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic go_write;  // accepted append has bytes to write
        logic go_read;   // accepted read has bytes to fetch
        logic last;      // current step is the final byte
        logic out_free;  // output register can take a result this cycle
    } sts_t;

endpackage

>>> rtl/core/lbs_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module lbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/lbs_ctrl.sv
// Controller state machine of the bit stream store.
// Depends on lbs_pkg.
module lbs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  lbs_pkg::sts_t sts,
    output lbs_pkg::cmd_t cmd
);
    import lbs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.go_write)
                    begin
                        state_next = S_WRITE;
                    end
                    else if (sts.go_read)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_WRITE:
            begin
                cmd.wr_step = 1'b1;
                if (sts.last)
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                cmd.rd_step = 1'b1;
                if (sts.last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last byte lands in the datapath this cycle
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/lbs_datapath.sv
// Datapath of the bit stream store: checks, fill count, tail byte, byte shifter,
// byte memory and output register.
// Depends on lbs_pkg and lbs_ram.
module lbs_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lbs_pkg::cmd_t                cmd,
    output lbs_pkg::sts_t                sts,
    input  logic [lbs_pkg::ACT_W-1:0]    action,
    input  logic [lbs_pkg::VAL_W-1:0]    field_value,
    input  logic [lbs_pkg::LEN_W-1:0]    field_bits,
    input  logic [lbs_pkg::FILL_W-1:0]   read_offset,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [lbs_pkg::VAL_W-1:0]    read_value,
    output logic [lbs_pkg::STAT_W-1:0]   status,
    output logic [lbs_pkg::FILL_W-1:0]   fill_bits,
    output logic [lbs_pkg::BYTES_W-1:0]  fill_bytes
);
    import lbs_pkg::*;

    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [BYTE_W-1:0]  tail_reg;
    logic [SPAN_W-1:0]  data_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [2:0]         sh_reg;
    logic [STAT_W-1:0]  stat_reg;
    logic               rd_ok_reg;
    logic               rd_pend_reg;

    logic               out_valid_reg;
    logic [VAL_W-1:0]   read_value_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [FILL_W-1:0]  fill_bits_reg;
    logic [BYTES_W-1:0] fill_bytes_reg;

    logic [FILL_W:0]    app_end;
    logic               bad_len;
    logic [STAT_W-1:0]  stat_c;
    logic               rd_ok_c;
    logic               go_write_c;
    logic               go_read_c;
    logic [2:0]         fill_frac;
    logic [BYTE_W-1:0]  tail_keep;
    logic [SPAN_W-1:0]  wr_init;
    logic [BYTE_W-1:0]  wcnt_sum;
    logic [VAL_W-1:0]   rd_field;
    logic [FILL_W:0]    bytes_sum;
    logic [BYTE_W-1:0]  mem_rdata;

    // Checks on the incoming transaction against the current fill
    assign app_end = {1'b0, fill_reg} + (FILL_W + 1)'(field_bits);
    assign bad_len = (field_bits > LEN_W'(MAX_FIELD));

    always_comb
    begin
        stat_c     = ST_OK;
        rd_ok_c    = 1'b0;
        go_write_c = 1'b0;
        go_read_c  = 1'b0;
        fill_next  = fill_reg;
        case (action)
            ACT_APPEND:
            begin
                if (bad_len)
                begin
                    stat_c = ST_BAD_LEN;
                end
                else if (app_end > (FILL_W + 1)'(CAP_BITS))
                begin
                    stat_c = ST_FULL;
                end
                else
                begin
                    go_write_c = (field_bits != '0);
                    fill_next  = app_end[FILL_W-1:0];
                end
            end
            ACT_READ:
            begin
                if (bad_len)
                begin
                    stat_c = ST_BAD_LEN;
                end
                else if (read_offset > fill_reg)
                begin
                    stat_c = ST_OFFSET;
                end
                else if (FILL_W'(field_bits) > (fill_reg - read_offset))
                begin
                    stat_c = ST_SPAN;
                end
                else
                begin
                    rd_ok_c   = 1'b1;
                    go_read_c = (field_bits != '0);
                end
            end
            ACT_CLEAR:
            begin
                fill_next = '0;
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
    end

    // Merge the kept low bits of the partial tail byte with the new field
    assign fill_frac = fill_reg[2:0];
    assign tail_keep = tail_reg & (8'hFF >> (4'd8 - {1'b0, fill_frac}));
    assign wr_init   = ({{BYTE_W{1'b0}}, field_value} << fill_frac)
                     | {{VAL_W{1'b0}}, tail_keep};
    assign wcnt_sum  = BYTE_W'(fill_frac) + BYTE_W'(field_bits) + 8'd7;

    assign rd_field  = VAL_W'(data_reg >> sh_reg) & ~({VAL_W{1'b1}} << len_reg);
    assign bytes_sum = {1'b0, fill_reg} + (FILL_W + 1)'(7);

    lbs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CAP_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.wr_step),
        .addr  (addr_reg),
        .wdata (data_reg[BYTE_W-1:0]),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.rd_step;
            if (cmd.load)
            begin
                fill_reg <= fill_next;
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            stat_reg  <= stat_c;
            rd_ok_reg <= rd_ok_c;
            len_reg   <= field_bits;
            sh_reg    <= read_offset[2:0];
            if (action == ACT_APPEND)
            begin
                addr_reg <= fill_reg[ADDR_W+2:3];
                data_reg <= wr_init;
                cnt_reg  <= wcnt_sum[CNT_W+2:3];
            end
            else
            begin
                addr_reg <= read_offset[ADDR_W+2:3];
                cnt_reg  <= CNT_W'(RD_BYTES);
            end
        end
        else if (cmd.wr_step)
        begin
            tail_reg <= data_reg[BYTE_W-1:0];
            data_reg <= data_reg >> BYTE_W;
            addr_reg <= addr_reg + 1'b1;
            cnt_reg  <= cnt_reg - 1'b1;
        end
        else
        begin
            if (cmd.rd_step)
            begin
                addr_reg <= addr_reg + 1'b1;
                cnt_reg  <= cnt_reg - 1'b1;
            end
            if (rd_pend_reg)
            begin
                data_reg <= {mem_rdata, data_reg[SPAN_W-1:BYTE_W]};
            end
        end

        if (cmd.publish)
        begin
            read_value_reg <= rd_ok_reg ? rd_field : '0;
            status_reg     <= stat_reg;
            fill_bits_reg  <= fill_reg;
            fill_bytes_reg <= bytes_sum[BYTES_W+2:3];
        end
    end

    assign sts.go_write = go_write_c;
    assign sts.go_read  = go_read_c;
    assign sts.last     = (cnt_reg == CNT_W'(1));
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign fill_bits  = fill_bits_reg;
    assign fill_bytes = fill_bytes_reg;

endmodule

>>> rtl/core/lsb_first_bit_stream_store.sv
// Top level of the LSB-first bit stream store: controller plus datapath.
// Depends on lbs_pkg, lbs_ctrl, lbs_datapath (which holds lbs_ram).
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------------------
//   input   | in_valid, in_ready  | action, field_value, field_bits, read_offset
//   output  | out_valid,out_ready | read_value, status, fill_bits, fill_bytes
//
// From one acceptance to the earliest next, an append of n > 0 bits runs accept,
// ceil((fill mod 8 + n) / 8) byte writes and publish; a read of n > 0 bits runs accept,
// nine byte reads, a drain and publish; clear, errors, zero-length fields and the
// unused action run accept and publish. The single memory port moves one byte per
// cycle. Reset clears the fill count and the output valid flag; memory contents are
// never cleared. A stalled output holds its result; one more transaction is taken and
// worked meanwhile, then waits.
module lsb_first_bit_stream_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [lbs_pkg::ACT_W-1:0]    action,
    input  logic [lbs_pkg::VAL_W-1:0]    field_value,
    input  logic [lbs_pkg::LEN_W-1:0]    field_bits,
    input  logic [lbs_pkg::FILL_W-1:0]   read_offset,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [lbs_pkg::VAL_W-1:0]    read_value,
    output logic [lbs_pkg::STAT_W-1:0]   status,
    output logic [lbs_pkg::FILL_W-1:0]   fill_bits,
    output logic [lbs_pkg::BYTES_W-1:0]  fill_bytes
);
    import lbs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequence the byte walk: accept, write or read bytes, publish
    lbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the fill, the partial tail byte, the byte memory and the result
    lbs_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .action      (action),
        .field_value (field_value),
        .field_bits  (field_bits),
        .read_offset (read_offset),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .read_value  (read_value),
        .status      (status),
        .fill_bits   (fill_bits),
        .fill_bytes  (fill_bytes)
    );

endmodule

>>> rtl/core/lbs_checker.sv
// Port-level checker for the bit stream store, bound to the top level.
// Depends on lbs_pkg and lsb_first_bit_stream_store.
module lbs_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [lbs_pkg::VAL_W-1:0]    read_value,
    input  logic [lbs_pkg::STAT_W-1:0]   status,
    input  logic [lbs_pkg::FILL_W-1:0]   fill_bits,
    input  logic [lbs_pkg::BYTES_W-1:0]  fill_bytes
);
    import lbs_pkg::*;

    logic [1:0] pend_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Count transactions accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(status))
        else $error("stalled result changed");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two transactions in flight");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result without an accepted transaction");

    a_bytes_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fill_bytes == BYTES_W'(((FILL_W + 1)'(fill_bits) + 15'd7) >> 3))
        else $error("fill_bytes does not match fill_bits");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> read_value == '0)
        else $error("error result carries a nonzero value");

endmodule

bind lsb_first_bit_stream_store lbs_checker u_lbs_checker (.*);

>>> test/tb_lsb_first_bit_stream_store.sv
`timescale 1ns / 100ps
// Self-checking testbench for lsb_first_bit_stream_store: directed, capacity and random tests
// against a bit-level shadow of the stream. Depends on lbs_pkg and the store RTL only.
module tb_lsb_first_bit_stream_store;

    import lbs_pkg::*;

    // Action code 3 is left unused by the block; it must pass through as a no-op
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int TICK_LIMIT    = 400_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int OFFSET_MAX    = (1 << FILL_W) - 1;
    localparam int LEN_MAX       = (1 << LEN_W) - 1;

    typedef struct packed {
        logic [VAL_W-1:0]   value;
        logic [STAT_W-1:0]  status;
        logic [FILL_W-1:0]  fill_bits;
        logic [BYTES_W-1:0] fill_bytes;
    } field_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [ACT_W-1:0]    action;
    logic [VAL_W-1:0]    field_value;
    logic [LEN_W-1:0]    field_bits;
    logic [FILL_W-1:0]   read_offset;
    logic                out_valid;
    logic                out_ready;
    logic [VAL_W-1:0]    read_value;
    logic [STAT_W-1:0]   status;
    logic [FILL_W-1:0]   fill_bits;
    logic [BYTES_W-1:0]  fill_bytes;

    // Shadow of the stream: one entry per stream bit, plus the fill point
    bit            stream_copy [0:CAP_BITS-1];
    int unsigned   stream_fill = 0;

    field_result_t pending_fields [$];
    int unsigned   ops_sent      = 0;
    int unsigned   mismatch_count = 0;
    int unsigned   clock_ticks   = 0;
    bit            steady_link   = 1'b0;

    lsb_first_bit_stream_store dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .field_value (field_value),
        .field_bits  (field_bits),
        .read_offset (read_offset),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value),
        .status      (status),
        .fill_bits   (fill_bits),
        .fill_bytes  (fill_bytes)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run; the slowest legal run stays far below this
    always @(posedge clk)
    begin
        clock_ticks++;
        if (clock_ticks == TICK_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_fields.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Work out the result of one accepted transaction and advance the shadow stream.
    // Length is checked first, then capacity (append) or offset and span (read).
    function automatic field_result_t predict_stream_op(input logic [ACT_W-1:0] act,
                                                        input logic [VAL_W-1:0] value,
                                                        input int unsigned nbits,
                                                        input int unsigned offset);
        field_result_t r;
        r = '0;
        r.status = ST_OK;
        case (act)
            ACT_APPEND:
            begin
                if (nbits > MAX_FIELD)
                    r.status = ST_BAD_LEN;
                else if (stream_fill + nbits > CAP_BITS)
                    r.status = ST_FULL;
                else
                begin
                    for (int k = 0; k < nbits; k++)
                        stream_copy[stream_fill + k] = value[k];
                    stream_fill += nbits;
                end
            end
            ACT_READ:
            begin
                if (nbits > MAX_FIELD)
                    r.status = ST_BAD_LEN;
                else if (offset > stream_fill)
                    r.status = ST_OFFSET;
                else if (nbits > stream_fill - offset)
                    r.status = ST_SPAN;
                else
                begin
                    for (int k = 0; k < nbits; k++)
                        r.value[k] = stream_copy[offset + k];
                end
            end
            ACT_CLEAR:
                stream_fill = 0;
            default:
                ;
        endcase
        r.fill_bits  = FILL_W'(stream_fill);
        r.fill_bytes = BYTES_W'((stream_fill + BYTE_W - 1) / BYTE_W);
        return r;
    endfunction

    // Three in ten draws are zero so back-to-back stretches show up even when idling
    function automatic int unsigned pick_wait();
        if (steady_link || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [VAL_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic int unsigned pick_length();
        case ($urandom_range(0, 9))
            0:       return ($urandom_range(0, 1) == 0) ? 0 : MAX_FIELD;
            1, 2:    return $urandom_range(1, 8);
            default: return $urandom_range(1, MAX_FIELD);
        endcase
    endfunction

    // Send one transaction: idle for a random gap, hold valid until accepted, then
    // record the expected result. Returns at the accepting rising edge.
    task automatic push_op(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] value,
                           input int unsigned nbits, input int unsigned offset);
        int unsigned gap;
        @(negedge clk);
        gap = pick_wait();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        action      <= act;
        field_value <= value;
        field_bits  <= LEN_W'(nbits);
        read_offset <= FILL_W'(offset);
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        pending_fields.push_back(predict_stream_op(act, value, nbits, offset));
        ops_sent++;
    endtask

    // Drop valid and hold the input side until every expected result is back
    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_fields.size() != 0)
            @(negedge clk);
    endtask

    // Well-formed read that stays inside the fill, often the longest that fits (at most 64 bits)
    task automatic push_read_inside();
        int unsigned top, n;
        top = (stream_fill < MAX_FIELD) ? stream_fill : MAX_FIELD;
        n = ($urandom_range(0, 3) == 0) ? top : $urandom_range(0, top);
        push_op(ACT_READ, rand_word(), n, $urandom_range(0, stream_fill - n));
    endtask

    // Read that ends at the fill or one bit past it, or starts one bit past it
    task automatic push_read_edge();
        int unsigned top, off, n;
        top = (stream_fill < MAX_FIELD) ? stream_fill : MAX_FIELD;
        if ($urandom_range(0, 4) == 0)
            push_op(ACT_READ, rand_word(), $urandom_range(0, MAX_FIELD), stream_fill + 1);
        else
        begin
            off = stream_fill - $urandom_range(0, top);
            n = stream_fill - off + $urandom_range(0, 1);
            if (n > MAX_FIELD)
                n = MAX_FIELD;
            push_op(ACT_READ, rand_word(), n, off);
        end
    endtask

    task automatic push_random(input int unsigned clear_pct);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < clear_pct)
            push_op(ACT_CLEAR, rand_word(), $urandom_range(0, LEN_MAX),
                    $urandom_range(0, OFFSET_MAX));
        else if (pick < clear_pct + 2)
            push_op(ACT_UNUSED, rand_word(), $urandom_range(0, LEN_MAX),
                    $urandom_range(0, OFFSET_MAX));
        else if (pick < clear_pct + 7)
            // noise: any length, any offset
            push_op(($urandom_range(0, 1) == 0) ? ACT_APPEND : ACT_READ, rand_word(),
                    $urandom_range(0, LEN_MAX), $urandom_range(0, OFFSET_MAX));
        else if (pick < clear_pct + 12)
            push_read_edge();
        else if (pick < 58)
            push_op(ACT_APPEND, rand_word(), pick_length(), $urandom_range(0, OFFSET_MAX));
        else
            push_read_inside();
    endtask

    // Extremes of every field, every action and each error path but ST_FULL on a short stream
    task automatic test_directed_cases();
        logic [VAL_W-1:0] pattern;
        pattern = rand_word();
        push_op(ACT_CLEAR, rand_word(), LEN_MAX, OFFSET_MAX);
        push_op(ACT_READ, '0, 0, 0);                   // empty read of an empty stream
        push_op(ACT_READ, '0, 1, 0);                   // span past an empty fill
        push_op(ACT_READ, '0, 0, 1);                   // offset past an empty fill
        push_op(ACT_APPEND, '1, 0, 0);                 // zero-length append changes nothing
        push_op(ACT_APPEND, '1, MAX_FIELD + 1, 0);
        push_op(ACT_APPEND, '1, LEN_MAX, OFFSET_MAX);
        push_op(ACT_APPEND, '1, MAX_FIELD, 0);
        push_op(ACT_APPEND, 64'hFFFF_FFFF_FFFF_FFFD, 3, 0); // only the low bits land
        push_op(ACT_APPEND, pattern, MAX_FIELD, 0);    // unaligned start
        push_op(ACT_APPEND, '0, MAX_FIELD, 0);
        push_op(ACT_READ, '0, MAX_FIELD, 0);
        push_op(ACT_READ, '0, MAX_FIELD, 3);           // nine bytes touched
        push_op(ACT_READ, '0, MAX_FIELD, 67);
        push_op(ACT_READ, '0, 3, 64);
        push_op(ACT_READ, '0, 0, stream_fill);
        push_op(ACT_READ, '0, 1, stream_fill);
        push_op(ACT_READ, '0, 0, stream_fill + 1);
        push_op(ACT_READ, '0, MAX_FIELD + 1, 0);
        push_op(ACT_READ, '0, LEN_MAX, OFFSET_MAX);    // length wins over offset
        push_op(ACT_READ, '0, MAX_FIELD, OFFSET_MAX);
        push_op(ACT_UNUSED, rand_word(), $urandom_range(0, LEN_MAX), OFFSET_MAX);
        push_op(ACT_READ, '0, MAX_FIELD, stream_fill - MAX_FIELD);
        push_op(ACT_CLEAR, '1, 0, 0);
        push_op(ACT_READ, '0, 0, 0);
        push_op(ACT_READ, '0, 1, 0);
    endtask

    // Fill the store to the last bit, probing the full status on the way and at the top
    task automatic test_fill_to_capacity();
        int unsigned room, n;
        push_op(ACT_CLEAR, rand_word(), $urandom_range(0, LEN_MAX), $urandom_range(0, OFFSET_MAX));
        while (stream_fill < CAP_BITS)
        begin
            room = CAP_BITS - stream_fill;
            n = ($urandom_range(0, 2) == 0) ? MAX_FIELD : $urandom_range(1, MAX_FIELD);
            if (n > room)
            begin
                push_op(ACT_APPEND, rand_word(), n, $urandom_range(0, OFFSET_MAX));
                n = room;
            end
            push_op(ACT_APPEND, rand_word(), n, $urandom_range(0, OFFSET_MAX));
            if ($urandom_range(0, 3) == 0)
                push_read_inside();
        end
        push_op(ACT_APPEND, rand_word(), 1, 0);
        push_op(ACT_APPEND, rand_word(), MAX_FIELD, 0);
        push_op(ACT_APPEND, rand_word(), 0, 0);
        push_op(ACT_APPEND, rand_word(), MAX_FIELD + 1, 0);
        push_op(ACT_READ, '0, MAX_FIELD, CAP_BITS - MAX_FIELD);
        push_op(ACT_READ, '0, 1, CAP_BITS - 1);
        push_op(ACT_READ, '0, 0, CAP_BITS);
        push_op(ACT_READ, '0, 1, CAP_BITS);
        push_op(ACT_READ, '0, 0, CAP_BITS + 1);
        push_op(ACT_READ, '0, MAX_FIELD, OFFSET_MAX);
        hold_until_drained();
    endtask

    // Runs of random traffic; each run picks how often the stream is cleared
    task automatic test_random_stream();
        int unsigned clear_pct, run_len;
        while (ops_sent < 1550)
        begin
            case ($urandom_range(0, 2))
                0:       clear_pct = 0;
                1:       clear_pct = 1;
                default: clear_pct = 6;
            endcase
            run_len = $urandom_range(60, 300);
            repeat (run_len)
                push_random(clear_pct);
            if ($urandom_range(0, 1) == 0)
                hold_until_drained();
        end
    endtask

    // Back-to-back traffic with the output always ready
    task automatic test_steady_link();
        steady_link = 1'b1;
        repeat (250)
            push_random(2);
        hold_until_drained();
        steady_link = 1'b0;
    endtask

    task automatic compare_field(input string label, input logic [VAL_W-1:0] want,
                                 input logic [VAL_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h, actual %h", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    // Output side: stall a random number of cycles before each result
    initial
    begin : drain_results
        int unsigned stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            stall = pick_wait();
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
        end
    end

    // Compare every result transaction with the oldest expectation
    always @(posedge clk)
    begin : check_results
        field_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (pending_fields.size() == 0)
            begin
                $display("%0t: result expected none, actual value %h status %h fill %0d",
                         $time, read_value, status, fill_bits);
                mismatch_count++;
            end
            else
            begin
                want = pending_fields.pop_front();
                compare_field("read_value", want.value, read_value);
                compare_field("status", VAL_W'(want.status), VAL_W'(status));
                compare_field("fill_bits", VAL_W'(want.fill_bits), VAL_W'(fill_bits));
                compare_field("fill_bytes", VAL_W'(want.fill_bytes), VAL_W'(fill_bytes));
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        action      = ACT_APPEND;
        field_value = '0;
        field_bits  = '0;
        read_offset = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_fill_to_capacity();
        test_random_stream();
        test_steady_link();

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/lbs_pkg.sv
rtl/core/lbs_ram.sv
rtl/core/lbs_ctrl.sv
rtl/core/lbs_datapath.sv
rtl/core/lsb_first_bit_stream_store.sv
rtl/core/lbs_checker.sv
test/tb_lsb_first_bit_stream_store.sv
